[sv/sobel_edge_magnitude_assert.svh]
// ----------------------------------------------------------------------------
// sobel edge magnitude assertion macros
// concurrent checks, disabled while the active-low reset is low
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SEM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sem_pkg.sv]
// ----------------------------------------------------------------------------
// sem_pkg
// shared types and constants of the sobel edge magnitude block
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int CFG_W          = 11;
    localparam int MIN_SIZE       = 3;
    localparam int QUEUE_DEPTH    = 2;   // power of two

    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

    // register index, taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [7:0] t_pix;

    // masked 3x3 neighborhood, index row*3+col
    typedef struct packed {
        t_pix [8:0] pix;
        logic       last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

[sv/sobel_edge_magnitude.sv]
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// 3x3 sobel gradient magnitude over a raster pixel stream
// ----------------------------------------------------------------------------
//
// channel   direction  handshake          payload
// pixel     in         i_valid / o_ready  i_pixel[7:0], i_flush
// result    out        o_valid / i_ready  o_magnitude[7:0], o_last
// config    in         apb psel/penable   paddr[2:0], pwdata, prdata
//
// the front reads the line stores on taking a word and writes them back before it takes the next
// each result passes through the back's square state, the 8-step bit-serial root and the done state;
// words that give no result pass only through the front
// a 2-entry queue lets the front run ahead while the back works or stalls
// the output register holds a result while the next one is being computed
// reset is synchronous; line stores need no clearing pass (edges are masked)
//
`default_nettype none

module sobel_edge_magnitude #(
    parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // pixel words
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_pixel,
    input  wire logic        i_flush,
    // result words
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_magnitude,
    output logic             o_last,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sem_pkg::*;

`include "sobel_edge_magnitude_assert.svh"

    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int HW = $clog2(MAX_HEIGHT+1);

    logic [CFG_W-1:0] r_image_width, r_image_height;
    logic             cfg_write;
    logic [WW-1:0]    w_width;
    logic [HW-1:0]    w_height;

    logic   w_push, w_pop;
    t_entry w_push_entry, w_pop_entry;
    t_qstat w_qstat;

    // register writes; any write restarts the image
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= SIZE_RESET;
            r_image_height <= SIZE_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = {{(32-CFG_W){1'b0}}, r_image_width};
            REG_IMAGE_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, r_image_height};
            default:          prdata = '0;
        endcase
    end

    // sizes clamped to [3, max]
    assign w_width  = (r_image_width < CFG_W'(MIN_SIZE)) ? WW'(MIN_SIZE)
                    : ({21'd0, r_image_width} > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH)
                    : WW'(r_image_width);
    assign w_height = (r_image_height < CFG_W'(MIN_SIZE)) ? HW'(MIN_SIZE)
                    : ({21'd0, r_image_height} > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
                    : HW'(r_image_height);

    sem_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_write),
        .i_width   (w_width),
        .i_height  (w_height),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_pixel   (i_pixel),
        .i_flush   (i_flush),
        .i_qstat   (w_qstat),
        .o_push    (w_push),
        .o_entry   (w_push_entry)
    );

    sem_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_pop_entry),
        .o_qstat (w_qstat)
    );

    sem_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (w_qstat),
        .i_entry     (w_pop_entry),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_magnitude (o_magnitude),
        .o_last      (o_last)
    );

    // the queue never takes a window it has no room for
    `SEM_ASSERT_SAME(a_push_room, i_clk, i_rst_n, w_push, !w_qstat.full, "queue overflow")
    // the back never pops an empty queue
    `SEM_ASSERT_SAME(a_pop_data, i_clk, i_rst_n, w_pop, !w_qstat.empty, "queue underflow")
    // the front is busy with the line store write right after taking a word
    `SEM_ASSERT_NEXT(a_front_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "front overrun")

endmodule

`default_nettype wire

[sv/sem_front.sv]
// ----------------------------------------------------------------------------
// sem_front
// position tracking, line stores and window; pushes masked windows
// ----------------------------------------------------------------------------
`default_nettype none

module sem_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_restart,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    i_width,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]   i_height,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [7:0]                        i_pixel,
    input  wire logic                              i_flush,
    input  wire sem_pkg::t_qstat                   i_qstat,
    output logic                                   o_push,
    output sem_pkg::t_entry                        o_entry
);
    import sem_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT+2);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic          r_state;
    logic [WW-1:0] r_col;
    logic [RW-1:0] r_row;

    t_pix          r_val;
    logic [AW-1:0] r_addr;
    logic          r_valid, r_last;
    logic          r_m_top, r_m_bot, r_m_left, r_m_right;
    t_pix          r_up_rd, r_mid_rd;
    t_pix [8:0]    r_win;
    t_pix [8:0]    n_win;

    t_pix mem_up  [MAX_WIDTH];
    t_pix mem_mid [MAX_WIDTH];

    logic          accept;
    logic [WW-1:0] ci, ci_inc, cc;
    logic [RW-1:0] rc, hgt;
    logic          valid, last;

    assign o_ready = (r_state == S_IDLE) && !i_qstat.full;
    assign accept  = i_valid && o_ready;

    assign hgt    = RW'(i_height);
    assign ci     = (r_col >= i_width) ? '0 : r_col;
    assign ci_inc = ci + WW'(1);
    assign valid  = (r_row >= RW'(2)) || (r_row == RW'(1) && ci != '0);
    assign cc     = (ci != '0) ? ci - WW'(1) : i_width - WW'(1);
    assign rc     = (ci != '0) ? r_row - RW'(1) : r_row - RW'(2);
    assign last   = valid && (rc == hgt - RW'(1)) && (cc == i_width - WW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= S_READ;
                r_valid <= valid;
            end else if (r_state == S_READ) begin
                r_state <= S_IDLE;
            end
            if (i_restart || (accept && last)) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (ci_inc >= i_width) begin
                    r_col <= '0;
                    r_row <= r_row + RW'(1);
                end else begin
                    r_col <= ci_inc;
                end
            end
        end
    end

    // payload of the item in flight
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val     <= i_flush ? '0 : i_pixel;
            r_addr    <= ci[AW-1:0];
            r_last    <= last;
            r_m_top   <= (rc != '0);
            r_m_bot   <= ((rc + RW'(1)) < hgt);
            r_m_left  <= (cc != '0);
            r_m_right <= ((cc + WW'(1)) < i_width);
        end
    end

    // line stores: read on accept, write back in the following cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up_rd  <= mem_up[ci[AW-1:0]];
            r_mid_rd <= mem_mid[ci[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            mem_up[r_addr]  <= r_mid_rd;
            mem_mid[r_addr] <= r_val;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3+0] = r_win[r*3+1];
            n_win[r*3+1] = r_win[r*3+2];
        end
        n_win[2] = r_up_rd;
        n_win[5] = r_mid_rd;
        n_win[8] = r_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_state == S_READ) begin
            r_win <= n_win;
        end
    end

    // zero the neighbors that fall outside the image
    always_comb begin
        logic keep;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                keep = 1'b1;
                if (r == 0) keep = keep & r_m_top;
                if (r == 2) keep = keep & r_m_bot;
                if (c == 0) keep = keep & r_m_left;
                if (c == 2) keep = keep & r_m_right;
                o_entry.pix[r*3+c] = keep ? n_win[r*3+c] : '0;
            end
        end
        o_entry.last = r_last;
    end

    assign o_push = (r_state == S_READ) && r_valid;

endmodule

`default_nettype wire

[sv/sem_queue.sv]
// ----------------------------------------------------------------------------
// sem_queue
// short window queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module sem_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire sem_pkg::t_entry i_entry,
    input  wire logic            i_pop,
    output sem_pkg::t_entry      o_entry,
    output sem_pkg::t_qstat      o_qstat
);
    import sem_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + PW'(1);
            if (i_pop)  r_rp <= r_rp + PW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + CW'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

    assign o_entry = r_mem[r_rp];
    assign o_qstat = '{full: (r_cnt == CW'(DEPTH)), empty: (r_cnt == '0)};

endmodule

`default_nettype wire

[sv/sem_back.sv]
// ----------------------------------------------------------------------------
// sem_back
// gradients, sum of squares, bit-serial root and output register
// ----------------------------------------------------------------------------
`default_nettype none

module sem_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sem_pkg::t_qstat i_qstat,
    input  wire sem_pkg::t_entry i_entry,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [7:0]           o_magnitude,
    output logic                 o_last
);
    import sem_pkg::*;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_SQ   = 2'd1;
    localparam logic [1:0] B_ROOT = 2'd2;
    localparam logic [1:0] B_DONE = 2'd3;

    logic [1:0]         r_state;
    logic signed [11:0] r_gx, r_gy;
    logic [20:0]        r_sq;
    logic [7:0]         r_root, r_bit;
    logic               r_last;
    logic               r_out_valid, r_out_last;
    logic [7:0]         r_out_mag;

    logic [9:0]         gx_pos, gx_neg, gy_pos, gy_neg;
    logic signed [23:0] px, py;
    logic [7:0]         trial;
    logic [15:0]        trial_sq;
    logic               load;

    // kernel sums, weights 1 2 1 on each side
    assign gx_pos = {2'b0, i_entry.pix[2]} + {1'b0, i_entry.pix[5], 1'b0}
                  + {2'b0, i_entry.pix[8]};
    assign gx_neg = {2'b0, i_entry.pix[0]} + {1'b0, i_entry.pix[3], 1'b0}
                  + {2'b0, i_entry.pix[6]};
    assign gy_pos = {2'b0, i_entry.pix[6]} + {1'b0, i_entry.pix[7], 1'b0}
                  + {2'b0, i_entry.pix[8]};
    assign gy_neg = {2'b0, i_entry.pix[0]} + {1'b0, i_entry.pix[1], 1'b0}
                  + {2'b0, i_entry.pix[2]};

    assign px       = r_gx * r_gx;
    assign py       = r_gy * r_gy;
    assign trial    = r_root | r_bit;
    assign trial_sq = trial * trial;

    assign o_pop = (r_state == B_IDLE) && !i_qstat.empty;
    assign load  = (r_state == B_DONE) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: if (o_pop) r_state <= B_SQ;
                B_SQ:   r_state <= B_ROOT;
                B_ROOT: if (r_bit[0]) r_state <= B_DONE;
                B_DONE: if (load) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_gx   <= $signed({2'b0, gx_pos}) - $signed({2'b0, gx_neg});
            r_gy   <= $signed({2'b0, gy_pos}) - $signed({2'b0, gy_neg});
            r_last <= i_entry.last;
        end
        if (r_state == B_SQ) begin
            r_sq   <= px[20:0] + py[20:0];
            r_root <= '0;
            r_bit  <= 8'h80;
        end
        // sums of 65536 and above saturate to 255 on their own
        if (r_state == B_ROOT) begin
            if ({5'b0, trial_sq} <= r_sq) r_root <= trial;
            r_bit <= r_bit >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_mag  <= r_root;
            r_out_last <= r_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_magnitude = r_out_mag;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire
